### hw/rtl/ptrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_pkg
// shared types, codes and helpers of the paper tape reader/punch
// ----------------------------------------------------------------------------
package ptrp_pkg;

   localparam int COUNT_BITS   = 22;
   localparam int CFG_BITS     = 20;
   localparam int CFG_IDX_BITS = 2;
   localparam int OP_BITS      = 4;
   localparam int BYTE_BITS    = 8;
   localparam int MODE_BITS    = 2;
   // wide enough for a count plus or minus a config value without overflow
   localparam int EXT_BITS     = ((COUNT_BITS > CFG_BITS + 1) ? COUNT_BITS : CFG_BITS + 1) + 2;

   localparam logic [BYTE_BITS-1:0] BYTE_EOT = 8'hFF;

   localparam logic [OP_BITS-1:0] OP_TICK        = 4'd0;
   localparam logic [OP_BITS-1:0] OP_RDR_MOUNT   = 4'd1;
   localparam logic [OP_BITS-1:0] OP_RDR_DISMNT  = 4'd2;
   localparam logic [OP_BITS-1:0] OP_RDR_START   = 4'd3;
   localparam logic [OP_BITS-1:0] OP_RDR_STOP    = 4'd4;
   localparam logic [OP_BITS-1:0] OP_RDR_READ    = 4'd5;
   localparam logic [OP_BITS-1:0] OP_PUN_MOUNT   = 4'd6;
   localparam logic [OP_BITS-1:0] OP_PUN_DISMNT  = 4'd7;
   localparam logic [OP_BITS-1:0] OP_PUN_START   = 4'd8;
   localparam logic [OP_BITS-1:0] OP_PUN_STOP    = 4'd9;
   localparam logic [OP_BITS-1:0] OP_PUNCH       = 4'd10;

   localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RDR  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PUN  = 2'd2;

   localparam logic [CFG_IDX_BITS-1:0] REG_READER_READY = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_READER_WAIT  = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_PUNCH_BUSY   = 2'd2;

   localparam logic [CFG_BITS-1:0] RESET_READER_READY = 20'd555;
   localparam logic [CFG_BITS-1:0] RESET_READER_WAIT  = 20'd1296;
   localparam logic [CFG_BITS-1:0] RESET_PUNCH_BUSY   = 20'd18518;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [BYTE_BITS-1:0] elapsed_cycles;
      logic [BYTE_BITS-1:0] tape_byte;
      logic                 tape_empty;
      logic [BYTE_BITS-1:0] punch_value;
   } req_word_type;

   typedef struct packed {
      logic                 unit_ready;
      logic [BYTE_BITS-1:0] read_data;
      logic                 mode_error;
      logic                 tape_taken;
      logic                 punch_valid;
      logic [BYTE_BITS-1:0] punch_byte;
      logic                 reader_at_end;
   } rsp_word_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] reader_ready_cycles;
      logic [CFG_BITS-1:0] reader_wait_cycles;
      logic [CFG_BITS-1:0] punch_busy_cycles;
   } cfg_type;

   // saturate a wide signed value into the signed count range
   function automatic logic signed [COUNT_BITS-1:0] clamp_count(
      input logic signed [EXT_BITS-1:0] v);
      logic signed [EXT_BITS-1:0] hi;
      logic signed [EXT_BITS-1:0] lo;
      logic signed [EXT_BITS-1:0] r;
      hi = $signed({{(EXT_BITS-COUNT_BITS+1){1'b0}}, {(COUNT_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) r = hi;
      else if (v < lo) r = lo;
      else r = v;
      return r[COUNT_BITS-1:0];
   endfunction

   function automatic logic signed [EXT_BITS-1:0] ext_cfg(input logic [CFG_BITS-1:0] v);
      return $signed({{(EXT_BITS-CFG_BITS){1'b0}}, v});
   endfunction

endpackage

### hw/rtl/ptrp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_if
// request and response channels of the paper tape reader/punch
// ----------------------------------------------------------------------------
interface ptrp_req_if import ptrp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_BITS-1:0]   op;
   logic [BYTE_BITS-1:0] elapsed_cycles;
   logic [BYTE_BITS-1:0] tape_byte;
   logic                 tape_empty;
   logic [BYTE_BITS-1:0] punch_value;

   modport source (output valid, op, elapsed_cycles, tape_byte, tape_empty, punch_value,
                   input ready);
   modport sink   (input valid, op, elapsed_cycles, tape_byte, tape_empty, punch_value,
                   output ready);
endinterface

interface ptrp_rsp_if import ptrp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 unit_ready;
   logic [BYTE_BITS-1:0] read_data;
   logic                 mode_error;
   logic                 tape_taken;
   logic                 punch_valid;
   logic [BYTE_BITS-1:0] punch_byte;
   logic                 reader_at_end;

   modport source (output valid, unit_ready, read_data, mode_error, tape_taken,
                   punch_valid, punch_byte, reader_at_end, input ready);
   modport sink   (input valid, unit_ready, read_data, mode_error, tape_taken,
                   punch_valid, punch_byte, reader_at_end, output ready);
endinterface

### hw/rtl/ptrp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_csr
// timing configuration registers, write only
// ----------------------------------------------------------------------------
module ptrp_csr import ptrp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CFG_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_READER_READY: cfg_in.reader_ready_cycles = csr_wdata;
            REG_READER_WAIT:  cfg_in.reader_wait_cycles  = csr_wdata;
            REG_PUNCH_BUSY:   cfg_in.punch_busy_cycles   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reader_ready_cycles <= RESET_READER_READY;
         cfg_ff.reader_wait_cycles  <= RESET_READER_WAIT;
         cfg_ff.punch_busy_cycles   <= RESET_PUNCH_BUSY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/ptrp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_engine
// device state and combinational event logic for reader and punch modes
// ----------------------------------------------------------------------------
module ptrp_engine import ptrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type item,
   input  cfg_type      cfg,
   output rsp_word_type result
);

   logic [MODE_BITS-1:0]         mode_ff,    mode_in;
   logic                         motor_ff,   motor_in;
   logic                         ready_ff,   ready_in;
   logic                         mounted_ff, mounted_in;
   logic                         end_ff,     end_in;
   logic [BYTE_BITS-1:0]         held_ff,    held_in;
   logic signed [COUNT_BITS-1:0] phase_ff,   phase_in;

   logic                         err;
   logic                         taken;
   logic                         pvalid;
   logic [BYTE_BITS-1:0]         pbyte;
   logic                         rdr_op;
   logic                         pun_op;
   logic signed [EXT_BITS-1:0]   phase_ext;
   logic signed [EXT_BITS-1:0]   diff;
   logic signed [COUNT_BITS-1:0] diff_c;
   logic signed [EXT_BITS-1:0]   diff_c_ext;

   assign rdr_op = (item.op >= OP_RDR_MOUNT) && (item.op <= OP_RDR_READ);
   assign pun_op = (item.op >= OP_PUN_MOUNT) && (item.op <= OP_PUNCH);

   assign phase_ext  = {{(EXT_BITS-COUNT_BITS){phase_ff[COUNT_BITS-1]}}, phase_ff};
   assign diff       = phase_ext - $signed({{(EXT_BITS-BYTE_BITS){1'b0}}, item.elapsed_cycles});
   assign diff_c     = clamp_count(diff);
   assign diff_c_ext = {{(EXT_BITS-COUNT_BITS){diff_c[COUNT_BITS-1]}}, diff_c};

   always_comb begin
      mode_in    = mode_ff;
      motor_in   = motor_ff;
      ready_in   = ready_ff;
      mounted_in = mounted_ff;
      end_in     = end_ff;
      held_in    = held_ff;
      phase_in   = phase_ff;
      err        = 1'b0;
      taken      = 1'b0;
      pvalid     = 1'b0;
      pbyte      = '0;
      if ((rdr_op && mode_ff == MODE_PUN) || (pun_op && mode_ff == MODE_RDR)) begin
         err = 1'b1;
      end else begin
         case (item.op)
            OP_TICK: begin
               if (mode_ff == MODE_PUN) begin
                  if (mounted_ff) begin
                     phase_in = diff_c;
                     if (diff_c <= 0) begin
                        ready_in = 1'b1;
                        phase_in = '0;
                     end
                  end
               end else if (motor_ff && !end_ff && mounted_ff) begin
                  phase_in = diff_c;
                  if (diff_c <= 0) begin
                     if (ready_ff) begin
                        ready_in = 1'b0;
                        phase_in = clamp_count(diff_c_ext + ext_cfg(cfg.reader_wait_cycles));
                     end else begin
                        ready_in = 1'b1;
                        phase_in = clamp_count(diff_c_ext + ext_cfg(cfg.reader_ready_cycles));
                        taken    = 1'b1;
                        if (item.tape_empty) begin
                           end_in  = 1'b1;
                           held_in = BYTE_EOT;
                        end else begin
                           held_in = item.tape_byte;
                        end
                     end
                  end
               end
            end
            OP_RDR_MOUNT: begin
               mounted_in = 1'b1;
               motor_in   = 1'b0;
               ready_in   = 1'b0;
               end_in     = 1'b0;
               held_in    = BYTE_EOT;
               phase_in   = clamp_count(ext_cfg(cfg.reader_wait_cycles));
               mode_in    = MODE_RDR;
            end
            OP_RDR_DISMNT: begin
               mounted_in = 1'b0;
               motor_in   = 1'b0;
               ready_in   = 1'b0;
               end_in     = 1'b1;
               held_in    = BYTE_EOT;
               mode_in    = MODE_NONE;
            end
            OP_RDR_START, OP_RDR_STOP: begin
               motor_in = (item.op == OP_RDR_START);
               ready_in = 1'b0;
               phase_in = clamp_count(ext_cfg(cfg.reader_wait_cycles));
            end
            OP_PUN_MOUNT: begin
               mode_in    = MODE_PUN;
               mounted_in = 1'b1;
               motor_in   = 1'b0;
               ready_in   = 1'b0;
               phase_in   = clamp_count(ext_cfg(cfg.punch_busy_cycles));
            end
            OP_PUN_DISMNT: begin
               mounted_in = 1'b0;
               motor_in   = 1'b0;
               ready_in   = 1'b1;
            end
            OP_PUN_START: begin
               motor_in = 1'b1;
               ready_in = 1'b0;
               phase_in = clamp_count(ext_cfg(cfg.punch_busy_cycles));
            end
            OP_PUN_STOP: begin
               motor_in = 1'b0;
               phase_in = clamp_count(ext_cfg(cfg.punch_busy_cycles));
            end
            OP_PUNCH: begin
               if (motor_ff && mounted_ff) begin
                  pvalid   = 1'b1;
                  pbyte    = item.punch_value;
                  ready_in = 1'b0;
                  phase_in = clamp_count(ext_cfg(cfg.punch_busy_cycles));
               end
            end
            default: begin
               // reader read and unknown ops leave the state alone
               err = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NONE;
         motor_ff   <= 1'b0;
         ready_ff   <= 1'b0;
         mounted_ff <= 1'b0;
         end_ff     <= 1'b1;
         held_ff    <= BYTE_EOT;
         phase_ff   <= '0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         motor_ff   <= motor_in;
         ready_ff   <= ready_in;
         mounted_ff <= mounted_in;
         end_ff     <= end_in;
         held_ff    <= held_in;
         phase_ff   <= phase_in;
      end
   end

   assign result.unit_ready    = ready_in;
   assign result.read_data     = held_in;
   assign result.mode_error    = err;
   assign result.tape_taken    = taken;
   assign result.punch_valid   = pvalid;
   assign result.punch_byte    = pbyte;
   assign result.reader_at_end = end_in;

   a_end_holds_eot: assert property (@(posedge clock) disable iff (reset)
      end_ff |-> held_ff == BYTE_EOT)
      else $error("end of tape without eot byte held");

   a_punch_clears_ready: assert property (@(posedge clock) disable iff (reset)
      fire && result.punch_valid |-> !result.mode_error && !result.unit_ready)
      else $error("punch left ready set or flagged an error");

   a_taken_on_reader_tick: assert property (@(posedge clock) disable iff (reset)
      fire && result.tape_taken |-> item.op == OP_TICK && mode_ff != MODE_PUN
                                    && result.unit_ready)
      else $error("tape byte taken outside a reader tick");

   a_mode_on_mount: assert property (@(posedge clock) disable iff (reset)
      fire && !result.mode_error && item.op == OP_PUN_MOUNT |=> mode_ff == MODE_PUN)
      else $error("punch mount did not enter punch mode");

endmodule

### hw/rtl/paper_tape_reader_punch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paper_tape_reader_punch
// shared paper tape reader/punch event engine, one response word per event
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req_ch   in   valid / ready          op, elapsed_cycles, tape_byte,
//                                       tape_empty, punch_value
//  rsp_ch   out  valid / ready          unit_ready, read_data, mode_error,
//                                       tape_taken, punch_valid, punch_byte,
//                                       reader_at_end
//  csr_*    in   csr_we, no wait        csr_index, csr_wdata (20 bits)
//
//  one word per clock sustained while rsp ready stays high; a word passes the input
//  register and then the output register before rsp valid rises for it
//  the event logic is combinational between the input and output registers,
//  so the state loop (counter subtract, reload add, saturate) sets the clock
//  reset is synchronous, active high; config back to power-on timings
//  a stalled rsp word holds in the output register while one more req word
//  is still taken into the input register
// ----------------------------------------------------------------------------
module paper_tape_reader_punch import ptrp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CFG_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   ptrp_req_if.sink                req_ch,
   ptrp_rsp_if.source              rsp_ch
);

   // input register stage
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff,  in_word_in;
   // output register stage
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff,  out_word_in;

   logic         advance;
   logic         req_fire;
   cfg_type      cfg;
   rsp_word_type result;

   // event moves from input to output register when the output slot frees
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   // gather the request word
   always_comb begin
      in_word_in  = in_word_ff;
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_word_in.op             = req_ch.op;
         in_word_in.elapsed_cycles = req_ch.elapsed_cycles;
         in_word_in.tape_byte      = req_ch.tape_byte;
         in_word_in.tape_empty     = req_ch.tape_empty;
         in_word_in.punch_value    = req_ch.punch_value;
         in_valid_in               = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // response word lands here; cleared valid once taken with nothing behind
   always_comb begin
      out_word_in  = out_word_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_word_in  = result;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   ptrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // device state updates exactly when an event passes to the output stage
   ptrp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.unit_ready    = out_word_ff.unit_ready;
   assign rsp_ch.read_data     = out_word_ff.read_data;
   assign rsp_ch.mode_error    = out_word_ff.mode_error;
   assign rsp_ch.tape_taken    = out_word_ff.tape_taken;
   assign rsp_ch.punch_valid   = out_word_ff.punch_valid;
   assign rsp_ch.punch_byte    = out_word_ff.punch_byte;
   assign rsp_ch.reader_at_end = out_word_ff.reader_at_end;

   a_stall_keeps_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_word_ff))
      else $error("stalled response word lost");

   a_no_advance_into_full: assert property (@(posedge clock) disable iff (reset)
      advance |-> !out_valid_ff || rsp_ch.ready)
      else $error("event overwrote a pending response");

   a_full_input_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("held request word dropped");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the paper tape reader/punch: reader and punch
// sessions with random content and idling on both channels, each response
// word checked field by field against a cycle-free prediction of the device
// ----------------------------------------------------------------------------
module testbench import ptrp_pkg::*; ();

   localparam int STALL_LIMIT = 3000;
   localparam logic [CFG_BITS-1:0]     CFG_MAX         = '1;
   localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED      = 2'd3;
   localparam logic [OP_BITS-1:0]      OP_FIRST_UNUSED = 4'd11;
   localparam logic [OP_BITS-1:0]      OP_LAST_UNUSED  = 4'd15;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CFG_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   ptrp_req_if req_ch ();
   ptrp_rsp_if rsp_ch ();

   paper_tape_reader_punch dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // idling odds in percent, and a long receiver hold-off on request
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;

   int words_sent    = 0;
   int words_checked = 0;
   int fail_count    = 0;

   // predicted device state and its own copy of the timing registers
   logic [MODE_BITS-1:0]          dev_mode;
   logic                          motor_on;
   logic                          ready_on;
   logic                          tape_in;
   logic                          eot_seen;
   logic [BYTE_BITS-1:0]          last_byte;
   logic signed [COUNT_BITS-1:0]  count_val;
   logic [CFG_BITS-1:0]           ready_cyc;
   logic [CFG_BITS-1:0]           wait_cyc;
   logic [CFG_BITS-1:0]           busy_cyc;

   // status words the device still owes, oldest first
   rsp_word_type status_due[$];

   wire req_fire = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
   wire rsp_fire = (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);

   // ---------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // prediction of one event
   // ---------------------------------------------------------------------

   // the countdown sticks at the ends of its signed range
   function automatic logic signed [COUNT_BITS-1:0] saturate_count(input longint v);
      longint top;
      longint r;
      top = (longint'(1) << (COUNT_BITS - 1)) - 1;
      r = v;
      if (v > top) r = top;
      else if (v < -top - 1) r = -top - 1;
      return r[COUNT_BITS-1:0];
   endfunction

   function automatic rsp_word_type predict_device_event(input req_word_type w);
      rsp_word_type r;
      logic rdr_cmd;
      logic pun_cmd;
      r = '0;
      rdr_cmd = (w.op >= OP_RDR_MOUNT) && (w.op <= OP_RDR_READ);
      pun_cmd = (w.op >= OP_PUN_MOUNT) && (w.op <= OP_PUNCH);
      // a command for the other half of the device only flags an error
      if ((rdr_cmd && dev_mode == MODE_PUN) || (pun_cmd && dev_mode == MODE_RDR)) begin
         r.mode_error = 1'b1;
      end else begin
         case (w.op)
            OP_TICK: begin
               if (dev_mode == MODE_PUN) begin
                  // punch busy countdown, ready once it runs out
                  if (tape_in) begin
                     count_val = saturate_count(longint'(count_val)
                                                - longint'(w.elapsed_cycles));
                     if (count_val <= 0) begin
                        ready_on  = 1'b1;
                        count_val = '0;
                     end
                  end
               end else if (motor_on && !eot_seen && tape_in) begin
                  count_val = saturate_count(longint'(count_val)
                                             - longint'(w.elapsed_cycles));
                  if (count_val <= 0) begin
                     if (ready_on) begin
                        ready_on  = 1'b0;
                        count_val = saturate_count(longint'(count_val) + longint'(wait_cyc));
                     end else begin
                        // rising ready edge takes the next tape byte
                        ready_on     = 1'b1;
                        count_val    = saturate_count(longint'(count_val)
                                                      + longint'(ready_cyc));
                        r.tape_taken = 1'b1;
                        if (w.tape_empty) begin
                           eot_seen  = 1'b1;
                           last_byte = BYTE_EOT;
                        end else begin
                           last_byte = w.tape_byte;
                        end
                     end
                  end
               end
            end
            OP_RDR_MOUNT: begin
               tape_in   = 1'b1;
               motor_on  = 1'b0;
               ready_on  = 1'b0;
               eot_seen  = 1'b0;
               last_byte = BYTE_EOT;
               count_val = saturate_count(longint'(wait_cyc));
               dev_mode  = MODE_RDR;
            end
            OP_RDR_DISMNT: begin
               tape_in   = 1'b0;
               motor_on  = 1'b0;
               ready_on  = 1'b0;
               eot_seen  = 1'b1;
               last_byte = BYTE_EOT;
               dev_mode  = MODE_NONE;
            end
            OP_RDR_START, OP_RDR_STOP: begin
               motor_on  = (w.op == OP_RDR_START);
               ready_on  = 1'b0;
               count_val = saturate_count(longint'(wait_cyc));
            end
            OP_PUN_MOUNT: begin
               dev_mode  = MODE_PUN;
               tape_in   = 1'b1;
               motor_on  = 1'b0;
               ready_on  = 1'b0;
               count_val = saturate_count(longint'(busy_cyc));
            end
            OP_PUN_DISMNT: begin
               // mode is left alone (punch stays punch), ready comes back at once
               tape_in  = 1'b0;
               motor_on = 1'b0;
               ready_on = 1'b1;
            end
            OP_PUN_START: begin
               motor_on  = 1'b1;
               ready_on  = 1'b0;
               count_val = saturate_count(longint'(busy_cyc));
            end
            OP_PUN_STOP: begin
               motor_on  = 1'b0;
               count_val = saturate_count(longint'(busy_cyc));
            end
            OP_PUNCH: begin
               if (motor_on && tape_in) begin
                  r.punch_valid = 1'b1;
                  r.punch_byte  = w.punch_value;
                  ready_on      = 1'b0;
                  count_val     = saturate_count(longint'(busy_cyc));
               end
            end
            default: begin
               // read and unknown ops leave the state alone
            end
         endcase
      end
      r.unit_ready    = ready_on;
      r.read_data     = last_byte;
      r.reader_at_end = eot_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request side monitor: register copy and one prediction per word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_monitor
      req_word_type seen;
      if (reset) begin
         dev_mode  = MODE_NONE;
         motor_on  = 1'b0;
         ready_on  = 1'b0;
         tape_in   = 1'b0;
         eot_seen  = 1'b1;
         last_byte = BYTE_EOT;
         count_val = '0;
         ready_cyc = RESET_READER_READY;
         wait_cyc  = RESET_READER_WAIT;
         busy_cyc  = RESET_PUNCH_BUSY;
      end else begin
         if (csr_we === 1'b1) begin
            case (csr_index)
               REG_READER_READY: ready_cyc = csr_wdata;
               REG_READER_WAIT:  wait_cyc  = csr_wdata;
               REG_PUNCH_BUSY:   busy_cyc  = csr_wdata;
               default: begin
                  // no register behind this index
               end
            endcase
         end
         if (req_fire) begin
            seen.op             = req_ch.op;
            seen.elapsed_cycles = req_ch.elapsed_cycles;
            seen.tape_byte      = req_ch.tape_byte;
            seen.tape_empty     = req_ch.tape_empty;
            seen.punch_value    = req_ch.punch_value;
            status_due.push_back(predict_device_event(seen));
         end
      end
   end

   // ---------------------------------------------------------------------
   // response side: receiver idling and field checks
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t ns: response word %0d: %s", $time, words_checked, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // receiver: random stalls, or a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_checker
      rsp_word_type want;
      if (!reset && rsp_fire) begin
         if (status_due.size() == 0) begin
            report_mismatch("word arrived with nothing outstanding");
         end else begin
            want = status_due.pop_front();
            check_field("unit_ready", BYTE_BITS'(rsp_ch.unit_ready),
                        BYTE_BITS'(want.unit_ready));
            check_field("read_data", rsp_ch.read_data, want.read_data);
            check_field("mode_error", BYTE_BITS'(rsp_ch.mode_error),
                        BYTE_BITS'(want.mode_error));
            check_field("tape_taken", BYTE_BITS'(rsp_ch.tape_taken),
                        BYTE_BITS'(want.tape_taken));
            check_field("punch_valid", BYTE_BITS'(rsp_ch.punch_valid),
                        BYTE_BITS'(want.punch_valid));
            check_field("punch_byte", rsp_ch.punch_byte, want.punch_byte);
            check_field("reader_at_end", BYTE_BITS'(rsp_ch.reader_at_end),
                        BYTE_BITS'(want.reader_at_end));
         end
         words_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any word moving on either channel
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // every field random, tape end only now and then
   function automatic req_word_type rand_word(input logic [OP_BITS-1:0] op);
      req_word_type w;
      w.op             = op;
      w.elapsed_cycles = BYTE_BITS'($urandom_range(255));
      w.tape_byte      = BYTE_BITS'($urandom_range(255));
      w.tape_empty     = ($urandom_range(99) < 4);
      w.punch_value    = BYTE_BITS'($urandom_range(255));
      return w;
   endfunction

   // valid is only lowered for an idle gap, so it never drops and rises in one step
   task automatic send_word(input req_word_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid          <= 1'b1;
      req_ch.op             <= w.op;
      req_ch.elapsed_cycles <= w.elapsed_cycles;
      req_ch.tape_byte      <= w.tape_byte;
      req_ch.tape_empty     <= w.tape_empty;
      req_ch.punch_value    <= w.punch_value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      words_sent++;
   endtask

   task automatic send_op(input logic [OP_BITS-1:0] op);
      send_word(rand_word(op));
   endtask

   task automatic send_tick(input logic [7:0] elapsed, input logic [7:0] tbyte,
                            input logic tempty);
      req_word_type w;
      w = rand_word(OP_TICK);
      w.elapsed_cycles = elapsed;
      w.tape_byte      = tbyte;
      w.tape_empty     = tempty;
      send_word(w);
   endtask

   task automatic send_punch(input logic [7:0] value);
      req_word_type w;
      w = rand_word(OP_PUNCH);
      w.punch_value = value;
      send_word(w);
   endtask

   // stop offering, let every owed word come back, then cover the latency
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_BITS-1:0] rdy_len,
                            input logic [CFG_BITS-1:0] gap_len,
                            input logic [CFG_BITS-1:0] busy_len);
      wait_idle();
      write_reg(REG_READER_READY, rdy_len);
      write_reg(REG_READER_WAIT,  gap_len);
      write_reg(REG_PUNCH_BUSY,   busy_len);
      // junk write to the empty index must change nothing
      write_reg(REG_UNUSED, CFG_BITS'($urandom));
      csr_we <= 1'b0;
   endtask

   // reader sessions: mount, start, mostly ticks, some reads and noise
   task automatic gen_reader(input int count);
      int stop_at;
      int len;
      int pick;
      logic [OP_BITS-1:0] op;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         // idle device noise, never a punch mount since that mode sticks
         repeat ($urandom_range(2)) begin
            op = OP_BITS'($urandom_range(OP_PUN_DISMNT, OP_LAST_UNUSED));
            send_op(op);
         end
         send_op(OP_RDR_MOUNT);
         if ($urandom_range(99) < 30) send_op(OP_PUN_MOUNT);
         send_op(OP_RDR_START);
         len = $urandom_range(20, 80);
         repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               send_op(OP_TICK);
            end else if (pick < 78) begin
               send_op(OP_RDR_READ);
            end else if (pick < 82) begin
               send_op(OP_RDR_STOP);
            end else if (pick < 87) begin
               send_op(OP_RDR_START);
            end else if (pick < 93) begin
               op = OP_BITS'($urandom_range(OP_PUN_DISMNT, OP_PUNCH));
               send_op(op);
            end else if (pick < 96) begin
               op = OP_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
               send_op(op);
            end else begin
               op = OP_BITS'($urandom_range(OP_LAST_UNUSED));
               if (op == OP_PUN_MOUNT) op = OP_RDR_MOUNT;
               send_op(op);
            end
         end
         if ($urandom_range(99) < 70) send_op(OP_RDR_DISMNT);
      end
   endtask

   // punch sessions: mount, start, ticks and punches, reader commands as noise
   task automatic gen_punch(input int count);
      int stop_at;
      int len;
      int pick;
      logic [OP_BITS-1:0] op;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         send_op(OP_PUN_MOUNT);
         if ($urandom_range(99) < 30) begin
            op = OP_BITS'($urandom_range(OP_RDR_MOUNT, OP_RDR_READ));
            send_op(op);
         end
         send_op(OP_PUN_START);
         len = $urandom_range(10, 60);
         repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               send_op(OP_TICK);
            end else if (pick < 75) begin
               send_op(OP_PUNCH);
            end else if (pick < 79) begin
               send_op(OP_PUN_STOP);
            end else if (pick < 83) begin
               send_op(OP_PUN_START);
            end else if (pick < 90) begin
               op = OP_BITS'($urandom_range(OP_RDR_MOUNT, OP_RDR_READ));
               send_op(op);
            end else if (pick < 94) begin
               op = OP_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
               send_op(op);
            end else if (pick < 97) begin
               send_op(OP_PUN_DISMNT);
            end else begin
               send_op(OP_PUN_MOUNT);
            end
         end
         send_op(OP_PUN_STOP);
         if ($urandom_range(99) < 60) send_op(OP_PUN_DISMNT);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // power-on state, unused device, wrong mode, byte extremes, end of tape
   task automatic test_reader_directed();
      set_idling(18, 79);
      send_op(OP_RDR_READ);
      send_op(OP_LAST_UNUSED);
      send_tick(8'd255, 8'h12, 1'b0);
      // punch commands on the unused device are taken, nothing is punched
      send_op(OP_PUN_START);
      send_punch(8'h77);
      send_op(OP_PUN_DISMNT);
      send_op(OP_PUN_STOP);
      configure(20'd1, 20'd1, RESET_PUNCH_BUSY);
      send_op(OP_RDR_MOUNT);
      send_punch(8'h81);
      send_op(OP_PUN_MOUNT);
      send_op(OP_RDR_START);
      send_tick(8'd0, 8'h00, 1'b0);
      send_tick(8'd1, 8'h00, 1'b0);
      send_op(OP_RDR_READ);
      send_tick(8'd255, 8'hFF, 1'b0);
      send_tick(8'd255, 8'hA5, 1'b0);
      send_op(OP_RDR_STOP);
      send_tick(8'd255, 8'h3C, 1'b0);
      send_op(OP_RDR_START);
      send_tick(8'd255, 8'h5A, 1'b1);
      send_tick(8'd255, 8'hC3, 1'b0);
      send_op(OP_FIRST_UNUSED);
      send_op(OP_RDR_DISMNT);
   endtask

   task automatic test_reader_random();
      set_idling(18, 79);
      configure(CFG_BITS'($urandom_range(1, 600)), CFG_BITS'($urandom_range(1, 1300)),
                CFG_BITS'($urandom_range(1, 30000)));
      gen_reader(300);
      // ready window never runs out once open
      set_idling(79, 18);
      configure(CFG_MAX, CFG_BITS'($urandom_range(1, 400)), CFG_MAX);
      gen_reader(300);
      // short windows, no idling, and one long receiver hold-off to fill the block
      set_idling(0, 0);
      configure(CFG_BITS'($urandom_range(1, 40)), CFG_BITS'($urandom_range(1, 40)), 20'd1);
      hold_left = 150;
      gen_reader(300);
   endtask

   // shortest windows and largest steps push the count deep below zero
   task automatic test_count_floor();
      set_idling(0, 0);
      configure(20'd1, 20'd1, CFG_MAX);
      send_op(OP_RDR_MOUNT);
      send_op(OP_RDR_START);
      repeat (100) send_tick(8'd255, BYTE_BITS'($urandom_range(255)), 1'b0);
      send_op(OP_RDR_READ);
      send_op(OP_RDR_DISMNT);
   endtask

   // punch mode entry, reader lockout, punch byte extremes, dismount ready
   task automatic test_punch_directed();
      set_idling(18, 79);
      configure(RESET_READER_READY, RESET_READER_WAIT, 20'd2);
      send_op(OP_PUN_MOUNT);
      send_op(OP_RDR_READ);
      send_op(OP_RDR_MOUNT);
      send_op(OP_RDR_START);
      send_op(OP_RDR_STOP);
      send_op(OP_RDR_DISMNT);
      send_punch(8'h99);
      send_tick(8'd0, 8'h00, 1'b0);
      send_tick(8'd1, 8'h00, 1'b0);
      send_tick(8'd255, 8'hFF, 1'b1);
      send_op(OP_PUN_START);
      send_punch(8'h00);
      send_punch(8'hFF);
      send_tick(8'd255, 8'h00, 1'b0);
      send_op(OP_PUN_STOP);
      send_punch(8'h3C);
      send_op(OP_PUN_DISMNT);
      send_tick(8'd255, 8'h00, 1'b0);
      send_op(OP_LAST_UNUSED);
      send_op(OP_PUN_MOUNT);
   endtask

   task automatic test_punch_random();
      set_idling(18, 79);
      configure(CFG_BITS'($urandom_range(1, 600)), CFG_BITS'($urandom_range(1, 1300)),
                CFG_BITS'($urandom_range(1, 500)));
      gen_punch(170);
      set_idling(79, 18);
      configure(20'd1, CFG_MAX, CFG_MAX);
      gen_punch(170);
      set_idling(0, 0);
      configure(CFG_MAX, 20'd1, 20'd1);
      hold_left = 150;
      gen_punch(170);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.op             = OP_TICK;
      req_ch.elapsed_cycles = '0;
      req_ch.tape_byte      = '0;
      req_ch.tape_empty     = 1'b0;
      req_ch.punch_value    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reader_directed();
      test_reader_random();
      test_count_floor();
      // punch mode cannot be left without a reset, so it comes last
      test_punch_directed();
      test_punch_random();

      wait_idle();
      // wait on to catch any stray word
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
